// ===== rtl/stream_reassembly_byte_buffer_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the stream reassembly byte buffer
// Each check samples on clk_i and is disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef STREAM_REASSEMBLY_BYTE_BUFFER_UNIT_ASSERT_SVH
`define STREAM_REASSEMBLY_BYTE_BUFFER_UNIT_ASSERT_SVH

`ifndef SYNTH

// Property that must hold at every sampled clock edge.
`define SRBB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define SRBB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define SRBB_ASSERT(label, prop, msg)
`define SRBB_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ===== rtl/srbb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stream reassembly byte buffer package
// Shared constants and command codes of the reassembly byte buffer.
// ----------------------------------------------------------------------------
package srbb_pkg;

  // Width of the byte counters and of the message size register.
  localparam int unsigned CNT_W = 27;
  // Largest value the written counter may reach.
  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
  // Bytes carried by one append word.
  localparam int unsigned APPEND_LEN = 7;
  // Byte returned when nothing can be read.
  localparam logic [7:0] NO_BYTE = 8'hFF;

  // Stream widths.
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned IN_DATA_W  = 72;
  localparam int unsigned OUT_DATA_W = 40;

  // Command carried in the input tuser field.
  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND  = 2'd0,
    CMD_POP     = 2'd1,
    CMD_PEEK    = 2'd2,
    CMD_RESTART = 2'd3
  } cmd_e;

endpackage

// ===== rtl/srbb_ring.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte ring storage
// Single-port-write, single-port-read byte memory with registered read data.
// ----------------------------------------------------------------------------
module srbb_ring #(
  parameter int unsigned DEPTH = 2048,
  parameter int unsigned AW    = 11
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/stream_reassembly_byte_buffer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stream reassembly byte buffer
// Flat byte ring that collects transport payload and serves pops and peeks.
// ----------------------------------------------------------------------------
// Append: ST_ISSUE, ST_WRITE per stored byte (0 to 7), ST_CLIP. Pop, peek:
// ST_ISSUE, ST_READ (ST_CLIP if no byte). Restart: ST_ISSUE, ST_CLIP.
// Each ends in ST_DONE, which fills the output register. A word is taken only
// in ST_IDLE; the ring has one write port, so an append stores one byte a
// cycle. A new word is taken while a finished result waits at the output.
// Reset clears the counters, overflow flag and message size, not the ring.
`include "stream_reassembly_byte_buffer_unit_assert.svh"

module stream_reassembly_byte_buffer_unit #(
  parameter int unsigned RING_BYTES = 2048
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration write channel: total_message_bytes.
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [srbb_pkg::CNT_W-1:0]          cfg_data_i,
  // Input stream.
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // byte_0 [7:0], byte_1 .. byte_6 up to [55:48], peek_offset [71:56]
  input  logic [srbb_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // cmd [1:0]
  input  logic [srbb_pkg::CMD_W-1:0]          s_axis_tuser,
  // Output stream.
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // read_byte [7:0], read_valid [8], unparsed_bytes [35:9],
  // end_of_stream [36], overflowed [37], zero [39:38]
  output logic [srbb_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

  localparam int unsigned AW = $clog2(RING_BYTES);
  localparam int unsigned FW = $clog2(RING_BYTES + 1);
  localparam int unsigned CW = srbb_pkg::CNT_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WRITE,
    ST_READ,
    ST_CLIP,
    ST_DONE
  } state_e;

  state_e           state_q;
  srbb_pkg::cmd_e   cmd_q;
  logic [7:0]       bytes_q [srbb_pkg::APPEND_LEN];
  logic [15:0]      off_q;
  logic [CW-1:0]    written_q;
  logic [CW-1:0]    parsed_q;
  logic [CW-1:0]    total_q;
  logic [CW-1:0]    top_q;
  logic [AW-1:0]    wr_ptr_q;
  logic [AW-1:0]    rd_ptr_q;
  logic             ovf_q;
  logic [2:0]       k_q;
  logic [2:0]       idx_q;
  logic [7:0]       rd_byte_q;
  logic             rd_valid_q;

  logic             out_valid_q;
  logic [7:0]       out_byte_q;
  logic             out_rvalid_q;
  logic [CW-1:0]    out_unparsed_q;
  logic             out_eos_q;
  logic             out_ovf_q;

  logic [CW-1:0]    cnt_diff;
  logic [FW-1:0]    fill;
  logic [FW-1:0]    room;
  logic [CW-1:0]    cnt_room;
  logic [2:0]       room_k;
  logic [2:0]       cnt_k;
  logic [2:0]       app_k;
  logic             has_byte;
  logic             peek_ok;
  logic [AW:0]      peek_sum;
  logic [AW-1:0]    peek_addr;
  logic [AW-1:0]    wr_ptr_nx;
  logic [AW-1:0]    rd_ptr_nx;
  logic [CW-1:0]    clip;
  logic [CW-1:0]    unparsed;
  logic             out_free;

  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [7:0]       mem_wdata;
  logic             mem_re;
  logic [AW-1:0]    mem_raddr;
  logic [7:0]       mem_rdata;

  // Fill level and free room; the fill never exceeds the ring size.
  assign cnt_diff = written_q - parsed_q;
  assign fill     = cnt_diff[FW-1:0];
  assign room     = FW'(RING_BYTES) - fill;
  assign cnt_room = srbb_pkg::COUNT_MAX - written_q;
  assign has_byte = (fill != '0);

  // Bytes an append can store: limited by ring room and counter headroom.
  assign room_k = (room >= FW'(srbb_pkg::APPEND_LEN)) ? 3'(srbb_pkg::APPEND_LEN) : room[2:0];
  assign cnt_k  = (cnt_room >= CW'(srbb_pkg::APPEND_LEN)) ? 3'(srbb_pkg::APPEND_LEN)
                                                          : cnt_room[2:0];
  assign app_k  = (room_k < cnt_k) ? room_k : cnt_k;

  // Peek address; only used when the offset lies below the fill level,
  // so the offset is below the ring size and one wrap suffices.
  assign peek_ok   = (32'(off_q) < 32'(fill));
  assign peek_sum  = (AW+1)'(rd_ptr_q) + (AW+1)'(off_q);
  assign peek_addr = (peek_sum >= (AW+1)'(RING_BYTES))
                   ? AW'(peek_sum - (AW+1)'(RING_BYTES)) : peek_sum[AW-1:0];

  // Ring pointers advance with wrap at the ring size.
  assign wr_ptr_nx = (wr_ptr_q == AW'(RING_BYTES - 1)) ? '0 : wr_ptr_q + 1'b1;
  assign rd_ptr_nx = (rd_ptr_q == AW'(RING_BYTES - 1)) ? '0 : rd_ptr_q + 1'b1;

  // Written count clipped to the announced message size, then the status.
  assign clip     = (total_q < written_q) ? total_q : written_q;
  assign unparsed = (top_q > parsed_q) ? (top_q - parsed_q) : '0;
  assign out_free = !out_valid_q || m_axis_tready;

  // Memory port control.
  always_comb begin
    mem_we    = (state_q == ST_WRITE);
    mem_waddr = wr_ptr_q;
    mem_wdata = bytes_q[idx_q];
    mem_re    = (state_q == ST_ISSUE)
             && (((cmd_q == srbb_pkg::CMD_POP) && has_byte)
              || ((cmd_q == srbb_pkg::CMD_PEEK) && peek_ok));
    mem_raddr = (cmd_q == srbb_pkg::CMD_POP) ? rd_ptr_q : peek_addr;
  end

  srbb_ring #(
    .DEPTH (RING_BYTES),
    .AW    (AW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Sequencer, counters and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      cmd_q          <= srbb_pkg::CMD_APPEND;
      for (int i = 0; i < srbb_pkg::APPEND_LEN; i++) begin
        bytes_q[i] <= '0;
      end
      off_q          <= '0;
      written_q      <= '0;
      parsed_q       <= '0;
      total_q        <= '0;
      top_q          <= '0;
      wr_ptr_q       <= '0;
      rd_ptr_q       <= '0;
      ovf_q          <= 1'b0;
      k_q            <= '0;
      idx_q          <= '0;
      rd_byte_q      <= srbb_pkg::NO_BYTE;
      rd_valid_q     <= 1'b0;
      out_valid_q    <= 1'b0;
      out_byte_q     <= '0;
      out_rvalid_q   <= 1'b0;
      out_unparsed_q <= '0;
      out_eos_q      <= 1'b0;
      out_ovf_q      <= 1'b0;
    end else begin
      // Message size register.
      if (cfg_valid_i) begin
        total_q <= cfg_data_i;
      end

      // A finished result fills the output register; a taken word frees it.
      if ((state_q == ST_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            cmd_q <= srbb_pkg::cmd_e'(s_axis_tuser);
            for (int i = 0; i < srbb_pkg::APPEND_LEN; i++) begin
              bytes_q[i] <= s_axis_tdata[8*i +: 8];
            end
            off_q   <= s_axis_tdata[71:56];
            state_q <= ST_ISSUE;
          end
        end

        ST_ISSUE: begin
          rd_byte_q  <= srbb_pkg::NO_BYTE;
          rd_valid_q <= 1'b0;
          state_q    <= ST_CLIP;
          unique case (cmd_q)
            srbb_pkg::CMD_APPEND: begin
              k_q   <= app_k;
              idx_q <= '0;
              if (app_k != 3'(srbb_pkg::APPEND_LEN)) begin
                ovf_q <= 1'b1;
              end
              if (app_k != '0) begin
                state_q <= ST_WRITE;
              end
            end
            srbb_pkg::CMD_POP: begin
              if (has_byte) begin
                parsed_q <= parsed_q + 1'b1;
                rd_ptr_q <= rd_ptr_nx;
                state_q  <= ST_READ;
              end
            end
            srbb_pkg::CMD_PEEK: begin
              if (peek_ok) begin
                state_q <= ST_READ;
              end
            end
            srbb_pkg::CMD_RESTART: begin
              written_q <= '0;
              parsed_q  <= '0;
              wr_ptr_q  <= '0;
              rd_ptr_q  <= '0;
            end
            default: begin
              state_q <= ST_CLIP;
            end
          endcase
        end

        // One byte stored per cycle.
        ST_WRITE: begin
          written_q <= written_q + 1'b1;
          wr_ptr_q  <= wr_ptr_nx;
          idx_q     <= idx_q + 1'b1;
          if (idx_q + 3'd1 == k_q) begin
            state_q <= ST_CLIP;
          end
        end

        // Read data arrives; counters are already final.
        ST_READ: begin
          rd_byte_q  <= mem_rdata;
          rd_valid_q <= 1'b1;
          top_q      <= clip;
          state_q    <= ST_DONE;
        end

        ST_CLIP: begin
          top_q   <= clip;
          state_q <= ST_DONE;
        end

        ST_DONE: begin
          if (out_free) begin
            out_byte_q     <= rd_byte_q;
            out_rvalid_q   <= rd_valid_q;
            out_unparsed_q <= unparsed;
            out_eos_q      <= (parsed_q >= total_q);
            out_ovf_q      <= ovf_q;
            state_q        <= ST_IDLE;
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_ovf_q, out_eos_q, out_unparsed_q, out_rvalid_q,
                          out_byte_q};

  // Checks.
  `SRBB_ASSERT(a_fill_bound, (parsed_q <= written_q) && (cnt_diff <= CW'(RING_BYTES)), "ring fill out of range")
  `SRBB_ASSERT_NEXT(a_ovf_sticky, ovf_q, ovf_q, "overflow flag dropped")
  `SRBB_ASSERT_NEXT(a_pop_advance, (state_q == ST_ISSUE) && (cmd_q == srbb_pkg::CMD_POP) && has_byte, parsed_q == $past(parsed_q) + 27'd1, "pop did not advance parse count")
  `SRBB_ASSERT_NEXT(a_restart_clear, (state_q == ST_ISSUE) && (cmd_q == srbb_pkg::CMD_RESTART), (written_q == '0) && (parsed_q == '0), "restart did not clear counters")

endmodule
